// ===== rtl/int8_dot_product_requantize_assert.svh =====
// ----------------------------------------------------------------------------
// int8_dot_product_requantize assertion macros
// Clocked on clock, quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef INT8_DOT_PRODUCT_REQUANTIZE_ASSERT_SVH
`define INT8_DOT_PRODUCT_REQUANTIZE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared constants and types of the int8 dot product requantizer.
// ----------------------------------------------------------------------------
package dpr_pkg;

   localparam int MAX_ROW_LENGTH = 128;
   localparam int LANE_COUNT     = 4;
   localparam int LANES_CARRIED  = 4;

   localparam int BYTE_W   = 8;
   localparam int PROD_W   = 2 * BYTE_W;
   localparam int LSUM_W   = PROD_W + $clog2(LANES_CARRIED);
   localparam int ACC_W    = 24;
   localparam int ACC_NXT_W = ACC_W + 1;
   localparam int MAG_W    = ACC_W - 1;
   localparam int MULT_W   = 31;
   localparam int SHIFT_W  = 6;
   localparam int SCALED_W = MAG_W + MULT_W;
   localparam int ROUND_W  = 64;
   localparam int LANES_W  = 3;
   localparam int CSR_IDX_W = 1;

   localparam int PROD_MAX      = 16384;
   localparam int ACC_FIELD_MAX = (1 << (ACC_W - 1)) - 1;
   localparam int ACC_BOUND     = (PROD_MAX * MAX_ROW_LENGTH > ACC_FIELD_MAX) ?
                                  ACC_FIELD_MAX : PROD_MAX * MAX_ROW_LENGTH;
   localparam int Q_LIMIT       = 127;

   localparam logic [MULT_W-1:0]  MULT_RESET  = MULT_W'(65536);
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(16);

   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MULTIPLIER = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_SHIFT      = CSR_IDX_W'(1);

   typedef logic signed [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic mac_en;    // fold the accepted beat into the accumulator
      logic row_last;  // accepted beat closes the row
      logic mul_en;    // multiply magnitude by the scale
      logic out_load;  // round, shift, clamp into the output register
   } cmd_type;

endpackage

// ===== rtl/dpr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpr_ctrl
// Sequencer: accept beats, step the requantize stages, own rsp_valid.
// ----------------------------------------------------------------------------
module dpr_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_row_last,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output dpr_pkg::cmd_type cmd
);
   import dpr_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MUL   = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.mac_en   = 1'b0;
      cmd.row_last = req_row_last;
      cmd.mul_en   = 1'b0;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.mac_en = accept;
            if (accept && req_row_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_SHIFT;
         end
         ST_SHIFT: begin
            // hold until the output register can take the result
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/dpr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpr_datapath
// Lane MAC, saturating accumulator, scale multiply and round/clamp stage.
// ----------------------------------------------------------------------------
module dpr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  dpr_pkg::cmd_type                  cmd,
   input  dpr_pkg::byte_type                 act [dpr_pkg::LANES_CARRIED],
   input  dpr_pkg::byte_type                 wgt [dpr_pkg::LANES_CARRIED],
   input  logic [dpr_pkg::LANES_W-1:0]       lanes_valid,
   input  logic                              csr_wr_en,
   input  logic [dpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dpr_pkg::MULT_W-1:0]        csr_wr_data,
   output logic signed [dpr_pkg::BYTE_W-1:0] result_q,
   output logic                              clamped
);
   import dpr_pkg::*;

   logic [MULT_W-1:0]  mult_ff;
   logic [SHIFT_W-1:0] shift_ff;

   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [LSUM_W-1:0]    lane_sum;
   logic signed [ACC_NXT_W-1:0] acc_raw, acc_sat;
   logic                        neg_ff;
   logic [MAG_W-1:0]            mag_ff;
   logic [SCALED_W-1:0]         scaled_ff;

   logic [ROUND_W-1:0]  round_add, rounded, q_wide;
   logic                over;
   logic [BYTE_W-1:0]   q_mag, q_signed;
   logic signed [BYTE_W-1:0] result_q_ff;
   logic                clamped_ff;

   // Lanes beyond the valid count contribute nothing; counts above the lane
   // limit saturate to it.
   always_comb begin
      lane_sum = '0;
      for (int i = 0; i < LANES_CARRIED; i++) begin
         if ((i < LANE_COUNT) && (lanes_valid > LANES_W'(i))) begin
            lane_sum = lane_sum + LSUM_W'(act[i] * wgt[i]);
         end
      end
   end

   assign acc_raw = ACC_NXT_W'(acc_ff) + ACC_NXT_W'(lane_sum);

   always_comb begin
      priority if (acc_raw > ACC_NXT_W'(ACC_BOUND)) begin
         acc_sat = ACC_NXT_W'(ACC_BOUND);
      end else if (acc_raw < -ACC_NXT_W'(ACC_BOUND)) begin
         acc_sat = -ACC_NXT_W'(ACC_BOUND);
      end else begin
         acc_sat = acc_raw;
      end
   end

   assign acc_in = cmd.row_last ? '0 : ACC_W'(acc_sat);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         mult_ff  <= MULT_RESET;
         shift_ff <= SHIFT_RESET;
      end else begin
         if (cmd.mac_en) begin
            acc_ff <= acc_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_SCALE_MULTIPLIER: mult_ff  <= csr_wr_data;
               CSR_SCALE_SHIFT:      shift_ff <= csr_wr_data[SHIFT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Capture sign and magnitude of the finished row.
   always_ff @(posedge clock) begin
      if (cmd.mac_en && cmd.row_last) begin
         neg_ff <= acc_sat[ACC_NXT_W-1];
         mag_ff <= acc_sat[ACC_NXT_W-1] ? MAG_W'(-acc_sat) : MAG_W'(acc_sat);
      end
      if (cmd.mul_en) begin
         scaled_ff <= SCALED_W'(mag_ff) * SCALED_W'(mult_ff);
      end
   end

   // Round half away from zero on the magnitude, then shift and clamp.
   assign round_add = (shift_ff == '0) ? '0 :
                      (ROUND_W'(1) << (shift_ff - SHIFT_W'(1)));
   assign rounded   = ROUND_W'(scaled_ff) + round_add;
   assign q_wide    = rounded >> shift_ff;
   assign over      = q_wide > ROUND_W'(Q_LIMIT);
   assign q_mag     = over ? BYTE_W'(Q_LIMIT) : q_wide[BYTE_W-1:0];
   assign q_signed  = neg_ff ? (~q_mag + BYTE_W'(1)) : q_mag;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         result_q_ff <= q_signed;
         clamped_ff  <= over;
      end
   end

   assign result_q = result_q_ff;
   assign clamped  = clamped_ff;

endmodule

// ===== rtl/int8_dot_product_requantize.sv =====
`timescale 1ns / 1ps
// Timing: a beat without row_last is absorbed in its accept cycle; a row_last
//   beat passes the magnitude register, the scale multiply register and the
//   round/clamp output register, and waits longer if the output is stalled.
// Throughput: one beat per cycle inside a row; after a row end no beat is taken
//   until the registered 23x31 scale multiply and round/shift stage finish.
// Reset: synchronous, active high; clears the accumulator, loads the scale
//   registers with their defaults (65536, 16) and drops rsp_valid.
// ----------------------------------------------------------------------------
// int8_dot_product_requantize
// Four-lane int8 MAC over a row, then fixed-point requantize to int8.
// ----------------------------------------------------------------------------
module int8_dot_product_requantize (
   input  logic                               clock,
   input  logic                               reset,
   // request channel: one beat carries up to four activation/weight pairs
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [dpr_pkg::BYTE_W-1:0]  req_act_lane0,
   input  logic signed [dpr_pkg::BYTE_W-1:0]  req_act_lane1,
   input  logic signed [dpr_pkg::BYTE_W-1:0]  req_act_lane2,
   input  logic signed [dpr_pkg::BYTE_W-1:0]  req_act_lane3,
   input  logic signed [dpr_pkg::BYTE_W-1:0]  req_wgt_lane0,
   input  logic signed [dpr_pkg::BYTE_W-1:0]  req_wgt_lane1,
   input  logic signed [dpr_pkg::BYTE_W-1:0]  req_wgt_lane2,
   input  logic signed [dpr_pkg::BYTE_W-1:0]  req_wgt_lane3,
   input  logic [dpr_pkg::LANES_W-1:0]        req_lanes_valid,
   input  logic                               req_row_last,
   // response channel: one beat per finished row
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [dpr_pkg::BYTE_W-1:0]  rsp_result_q,
   output logic                               rsp_clamped,
   // configuration writes
   input  logic                               csr_wr_en,
   input  logic [dpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dpr_pkg::MULT_W-1:0]         csr_wr_data
);
   import dpr_pkg::*;

`include "int8_dot_product_requantize_assert.svh"

   cmd_type  cmd;
   byte_type act [LANES_CARRIED];
   byte_type wgt [LANES_CARRIED];

   // Gather the lane ports into arrays for the MAC.
   assign act[0] = req_act_lane0;
   assign act[1] = req_act_lane1;
   assign act[2] = req_act_lane2;
   assign act[3] = req_act_lane3;
   assign wgt[0] = req_wgt_lane0;
   assign wgt[1] = req_wgt_lane1;
   assign wgt[2] = req_wgt_lane2;
   assign wgt[3] = req_wgt_lane3;

   // Sequencer: takes beats while idle, walks a row end through the
   // multiply and round stages, and holds the result until it is taken.
   dpr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_row_last (req_row_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd)
   );

   // Datapath: lane products, saturating accumulator, scale registers,
   // multiply register and the output register.
   dpr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .act         (act),
      .wgt         (wgt),
      .lanes_valid (req_lanes_valid),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .result_q    (rsp_result_q),
      .clamped     (rsp_clamped)
   );

   // A row end leaves the sequencer busy for the requantize stages.
   `DPR_ASSERT_NEXT(a_last_blocks, req_valid && req_ready && req_row_last, !req_ready, "row end did not stall the request channel")
   // A mid-row beat never stalls the next one.
   `DPR_ASSERT_NEXT(a_mid_row_flows, req_valid && req_ready && !req_row_last, req_ready, "mid-row beat stalled the request channel")
   // A fresh result is only loaded from the round stage, never while idle.
   `DPR_ASSERT_SAME(a_rsp_from_round, $rose(rsp_valid), $past(!req_ready), "result appeared without a row end in flight")

endmodule

// ===== bench/tb_int8_dot_product_requantize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int8_dot_product_requantize
// Streams int8 activation/weight beats into the row MAC, predicts every row
// result with an independent accumulate/scale/round/clamp model, and compares
// each result beat against the oldest pending prediction under random stalls
// on both channels and across several scale settings.
// ----------------------------------------------------------------------------
module tb_int8_dot_product_requantize;
   import dpr_pkg::*;

   localparam int RESET_CYCLES  = 12;
   localparam int QUIET_CYCLES  = 8;          // well past the row latency
   localparam int RANDOM_BEATS  = 630;
   localparam int PHASES        = 6;
   localparam int RUN_LIMIT_NS  = 10_000_000;

   // Accumulator clips symmetrically at the row bound, never past the 24-bit field.
   localparam longint ROW_BOUND  = 64'sd16384 * MAX_ROW_LENGTH;
   localparam longint FIELD_PEAK = 64'sd8388607;
   localparam longint SUM_LIMIT  = (ROW_BOUND > FIELD_PEAK) ? FIELD_PEAK : ROW_BOUND;
   localparam int     USABLE_LANES = (LANE_COUNT > LANES_CARRIED) ? LANES_CARRIED
                                                                  : LANE_COUNT;

   localparam logic [MULT_W-1:0] MULT_PEAK = '1;

   typedef struct {
      byte_type             act [4];
      byte_type             wgt [4];
      logic [LANES_W-1:0]   lanes;
      logic                 last;
   } beat_type;

   // -------------------------------------------------------------------------
   // Row result tracker: running row sum, scale settings and the queue of
   // requantized results still owed by the block.
   // -------------------------------------------------------------------------
   class row_requant_tracker;
      typedef struct {
         byte_type q;
         logic     clamped;
      } requant_type;

      requant_type        expected_rows [$];
      longint             row_sum;
      logic [MULT_W-1:0]  multiplier;
      logic [SHIFT_W-1:0] shift;
      int                 errors;

      function new();
         row_sum    = 0;
         multiplier = MULT_RESET;
         shift      = SHIFT_RESET;
         errors     = 0;
      endfunction

      function void configure(logic [CSR_IDX_W-1:0] index, logic [MULT_W-1:0] data);
         if (index == CSR_SCALE_MULTIPLIER) begin
            multiplier = data;
         end else if (index == CSR_SCALE_SHIFT) begin
            shift = data[SHIFT_W-1:0];
         end
      endfunction

      // Fold an accepted beat into the row; on row end, queue the result.
      function void absorb_beat(beat_type b);
         int                 used;
         longint             sum;
         longint unsigned    mag;
         longint unsigned    scaled;
         bit                 neg;
         bit                 clip;
         requant_type        r;
         used = (int'(b.lanes) > USABLE_LANES) ? USABLE_LANES : int'(b.lanes);
         sum  = row_sum;
         for (int i = 0; i < used; i++) begin
            sum += longint'(b.act[i]) * longint'(b.wgt[i]);
         end
         if (sum > SUM_LIMIT) sum = SUM_LIMIT;
         if (sum < -SUM_LIMIT) sum = -SUM_LIMIT;
         row_sum = sum;
         if (!b.last) return;

         neg    = (sum < 0);
         mag    = neg ? -sum : sum;
         scaled = mag * longint'(multiplier);
         // round half away from zero on the magnitude; no rounding at shift 0
         if (shift != 0) begin
            scaled = (scaled + (64'd1 << (shift - 1))) >> shift;
         end
         clip = (scaled > 127);
         if (clip) scaled = 127;
         r.q       = neg ? -byte_type'(scaled) : byte_type'(scaled);
         r.clamped = clip;
         expected_rows.push_back(r);
         row_sum = 0;
      endfunction

      function void check_row(byte_type q, logic clamped);
         requant_type want;
         if (expected_rows.size() == 0) begin
            $display("%0t ns: result beat with no row pending: result_q %0d clamped %0b",
                     $time, q, clamped);
            errors++;
            return;
         end
         want = expected_rows.pop_front();
         if (q !== want.q) begin
            $display("%0t ns: result_q mismatch: expected %0d actual %0d",
                     $time, want.q, q);
            errors++;
         end
         if (clamped !== want.clamped) begin
            $display("%0t ns: clamped mismatch: expected %0b actual %0b",
                     $time, want.clamped, clamped);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block signals; every input starts at a known value.
   // -------------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   byte_type                req_act_lane0 = '0;
   byte_type                req_act_lane1 = '0;
   byte_type                req_act_lane2 = '0;
   byte_type                req_act_lane3 = '0;
   byte_type                req_wgt_lane0 = '0;
   byte_type                req_wgt_lane1 = '0;
   byte_type                req_wgt_lane2 = '0;
   byte_type                req_wgt_lane3 = '0;
   logic [LANES_W-1:0]      req_lanes_valid = '0;
   logic                    req_row_last = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   byte_type                rsp_result_q;
   logic                    rsp_clamped;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [MULT_W-1:0]       csr_wr_data = '0;

   row_requant_tracker tracker = new();
   bit                 sender_burst = 1'b0;   // hold valid high, no gaps, for a row
   int                 beats_sent = 0;

   int8_dot_product_requantize dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly back-to-back beats, some short gaps, a few long ones.
   function automatic int beat_gap();
      int roll;
      if (sender_burst) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic byte_type pick_byte(int lo, int hi);
      return byte_type'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   // Same pair in every lane: lanes past the count must drop out.
   function automatic beat_type uniform_beat(int a, int w, int lanes, bit last);
      beat_type b;
      for (int i = 0; i < 4; i++) begin
         b.act[i] = byte_type'(a);
         b.wgt[i] = byte_type'(w);
      end
      b.lanes = LANES_W'(lanes);
      b.last  = last;
      return b;
   endfunction

   // Lane count is mostly full, otherwise anything the field holds (0..7).
   function automatic beat_type random_beat(int lo, int hi, bit last);
      beat_type b;
      for (int i = 0; i < 4; i++) begin
         b.act[i] = pick_byte(lo, hi);
         b.wgt[i] = pick_byte(lo, hi);
      end
      b.lanes = ($urandom_range(0, 9) < 7) ? LANES_W'(4) : LANES_W'($urandom_range(0, 7));
      b.last  = last;
      return b;
   endfunction

   // Present one beat and hold it until the block takes it. Valid drops
   // only when a gap actually follows.
   task automatic send_beat(beat_type b);
      int gap;
      gap = beat_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_act_lane0   <= b.act[0];
      req_act_lane1   <= b.act[1];
      req_act_lane2   <= b.act[2];
      req_act_lane3   <= b.act[3];
      req_wgt_lane0   <= b.wgt[0];
      req_wgt_lane1   <= b.wgt[1];
      req_wgt_lane2   <= b.wgt[2];
      req_wgt_lane3   <= b.wgt[3];
      req_lanes_valid <= b.lanes;
      req_row_last    <= b.last;
      do @(posedge clock); while (!req_ready);
      tracker.absorb_beat(b);
      beats_sent++;
   endtask

   // Drop valid, wait until every owed row result has arrived, then let the
   // pipe settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Write both scale registers on consecutive edges; call only when idle.
   task automatic write_scale(logic [MULT_W-1:0] mult, logic [SHIFT_W-1:0] shift_amt);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SCALE_MULTIPLIER;
      csr_wr_data <= mult;
      @(posedge clock);
      tracker.configure(CSR_SCALE_MULTIPLIER, mult);
      csr_index   <= CSR_SCALE_SHIFT;
      csr_wr_data <= MULT_W'(shift_amt);
      @(posedge clock);
      tracker.configure(CSR_SCALE_SHIFT, MULT_W'(shift_amt));
      csr_wr_en   <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Result side: stall at random, with long stretches of steady ready.
   // -------------------------------------------------------------------------
   initial begin : result_backpressure
      int hold;
      int stall;
      int roll;
      do @(posedge clock); while (reset);
      forever begin
         rsp_ready <= 1'b1;
         hold = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
         repeat (hold) @(posedge clock);
         roll = $urandom_range(0, 99);
         if (roll < 70) stall = $urandom_range(1, 2);
         else if (roll < 95) stall = $urandom_range(3, 8);
         else stall = $urandom_range(20, 60);
         rsp_ready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
   end

   // Check every result beat at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_row(rsp_result_q, rsp_clamped);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      beat_type           b;
      logic [MULT_W-1:0]  mult;
      logic [SHIFT_W-1:0] shift_amt;
      int                 row_kind;
      int                 row_len;
      int                 phase_stop;
      bit                 negative_row;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset scale is a gain of exactly one: results equal the row sum.
      send_beat(uniform_beat(127, 127, 1, 1'b1));        // positive clamp
      b = random_beat(-128, 127, 1'b1);
      b.lanes = '0;                                      // zero lanes: empty row
      send_beat(b);
      send_beat(uniform_beat(3, -5, 7, 1'b1));           // lane count saturates to four
      send_beat(uniform_beat(-2, -7, 5, 1'b1));
      send_beat(uniform_beat(5, 6, 2, 1'b0));            // two-beat row
      send_beat(uniform_beat(-8, 7, 3, 1'b1));
      send_beat(uniform_beat(-128, -128, 4, 1'b1));      // largest product
      send_beat(uniform_beat(-128, 127, 4, 1'b1));       // negative clamp
      send_beat(uniform_beat(127, -128, 3, 1'b0));
      send_beat(uniform_beat(9, 9, 0, 1'b1));            // zero lanes closes a nonempty row

      // Gain of one half: exact halves round away from zero.
      drain_results();
      write_scale(MULT_W'(1), SHIFT_W'(1));
      send_beat(uniform_beat(3, 1, 1, 1'b1));
      send_beat(uniform_beat(-3, 1, 1, 1'b1));
      send_beat(uniform_beat(1, 1, 1, 1'b1));

      // Gain of one quarter: a small negative value rounds to zero.
      drain_results();
      write_scale(MULT_W'(1), SHIFT_W'(2));
      send_beat(uniform_beat(-1, 1, 1, 1'b1));
      send_beat(uniform_beat(-2, 1, 1, 1'b1));

      // Widest multiplier with no shift: anything nonzero clamps.
      drain_results();
      write_scale(MULT_PEAK, SHIFT_W'(0));
      send_beat(uniform_beat(1, 1, 1, 1'b1));
      send_beat(uniform_beat(0, 5, 4, 1'b1));
      send_beat(uniform_beat(-1, 1, 1, 1'b1));

      // Widest multiplier, widest shift: everything scales to zero.
      drain_results();
      write_scale(MULT_PEAK, '1);
      send_beat(uniform_beat(-128, -128, 4, 1'b1));

      drain_results();
      write_scale('0, SHIFT_W'(0));
      send_beat(uniform_beat(127, 127, 4, 1'b1));

      // Just under unity gain through the full multiplier width.
      drain_results();
      write_scale(MULT_PEAK, SHIFT_W'(31));
      send_beat(uniform_beat(-11, 11, 1, 1'b1));

      // Random rows, one scale setting per phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase)
            0, 2: begin
               mult      = MULT_W'($urandom_range(1 << 20, (1 << 21) - 1));
               shift_amt = SHIFT_W'($urandom_range(22, 32));
            end
            1: begin
               mult      = MULT_W'($urandom());
               shift_amt = SHIFT_W'($urandom_range(0, 63));
            end
            3: begin
               mult      = MULT_W'($urandom_range(1 << 30, 32'h7FFF_FFFF));
               shift_amt = SHIFT_W'($urandom_range(36, 46));
            end
            4: begin
               mult      = MULT_W'($urandom_range(1, 255));
               shift_amt = SHIFT_W'($urandom_range(8, 16));
            end
            default: begin
               mult      = $urandom_range(0, 1) ? MULT_PEAK : MULT_W'($urandom_range(0, 3));
               shift_amt = $urandom_range(0, 1) ? '1 : SHIFT_W'($urandom_range(0, 2));
            end
         endcase
         write_scale(mult, shift_amt);

         phase_stop = beats_sent + RANDOM_BEATS / PHASES;
         while (beats_sent < phase_stop) begin
            row_kind     = $urandom_range(0, 99);
            sender_burst = ($urandom_range(0, 9) < 2);
            if (row_kind < 6) begin
               // Overlong row: same-sign large products drive the sum into its bound.
               row_len      = $urandom_range(45, 70);
               negative_row = $urandom_range(0, 1);
               for (int k = 0; k < row_len; k++) begin
                  b = random_beat(-128, -112, k == row_len - 1);
                  b.lanes = LANES_W'(4);
                  if (negative_row) begin
                     for (int i = 0; i < 4; i++) b.wgt[i] = ~b.wgt[i];
                  end
                  send_beat(b);
               end
            end else if (row_kind < 16) begin
               // Short rows of small values: sums land near rounding steps.
               row_len = $urandom_range(1, 3);
               for (int k = 0; k < row_len; k++) begin
                  send_beat(random_beat(-4, 4, k == row_len - 1));
               end
            end else begin
               row_len = $urandom_range(1, 12);
               for (int k = 0; k < row_len; k++) begin
                  send_beat(random_beat(-128, 127, k == row_len - 1));
               end
            end
            sender_burst = 1'b0;
            // Now and then, hold off until every result is in.
            if ($urandom_range(0, 29) == 0) drain_results();
         end
      end

      drain_results();
      if (tracker.errors == 0) begin
         $display("int8_dot_product_requantize test passed");
      end else begin
         $display("int8_dot_product_requantize test failed");
      end
      $finish;
   end

   // Run guard: far beyond the slowest legal run.
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("int8_dot_product_requantize test failed");
      $finish;
   end

endmodule
